// ===== sv/gn2d_pkg.sv =====
// gn2d_pkg: shared widths, constants and tables for the 2D gradient noise block.
// No dependencies; imported by gn2d_corner and gradient_noise_2d.
package gn2d_pkg;

    // Input point format
    localparam int FRAC_BITS = 12;
    localparam int INT_BITS  = 10;
    localparam int COORD_W   = INT_BITS + FRAC_BITS;
    // Lattice index: two more integer bits for the 4x octave, one for the +1 corner
    localparam int GRID_W    = INT_BITS + 3;

    // Datapath widths
    localparam int OFS_W = 17;      // Q16 corner offset, signed
    localparam int CS_W  = 20;      // CORDIC x, y, z
    localparam int DOT_W = 38;      // Q32 dot products and blends
    localparam int WGT_W = 17;      // Q16 fade weight, 0..65536

    // Register map
    localparam logic REG_NOISE_SEED = 1'b0;

    // Corner hash
    localparam logic [31:0] HASH_M1 = 32'h045d_9f3b;
    localparam logic [31:0] HASH_M2 = 32'hc2b2_ae35;

    // h mod 62832 = ((h >> 4) mod 3927) * 16 + h[3:0]
    localparam logic [16:0] MOD_K = 17'd68356;     // floor(2^28 / 3927)
    localparam logic [11:0] MOD_D = 12'd3927;

    // 1e-4 rad to Q16 rad: (m*65536 + 5000) / 10000 = (m*4096 + 312) / 625
    localparam logic [18:0] DEG_K    = 19'd429496; // floor(2^28 / 625)
    localparam logic [9:0]  DEG_D    = 10'd625;
    localparam logic [27:0] DEG_BIAS = 28'd312;

    localparam logic signed [CS_W-1:0] Q16_PI      = 20'sd205887;
    localparam logic signed [CS_W-1:0] Q16_TWO_PI  = 20'sd411775;
    localparam logic signed [CS_W-1:0] Q16_HALF_PI = 20'sd102944;
    localparam logic signed [CS_W-1:0] CORDIC_GAIN = 20'sd39797;
    localparam int CORDIC_STEPS = 16;

    function automatic logic signed [CS_W-1:0] atan_q16(input int idx);
        logic signed [CS_W-1:0] r;
        case (idx)
            0:  r = 20'sd51472;
            1:  r = 20'sd30386;
            2:  r = 20'sd16055;
            3:  r = 20'sd8150;
            4:  r = 20'sd4091;
            5:  r = 20'sd2047;
            6:  r = 20'sd1024;
            7:  r = 20'sd512;
            8:  r = 20'sd256;
            9:  r = 20'sd128;
            10: r = 20'sd64;
            11: r = 20'sd32;
            12: r = 20'sd16;
            13: r = 20'sd8;
            14: r = 20'sd4;
            15: r = 20'sd2;
            default: r = 20'sd0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/gn2d_corner.sv =====
// gn2d_corner: one lattice corner, hash -> angle -> CORDIC -> dot product.
// 28 register stages, advanced by en. Depends on gn2d_pkg.
module gn2d_corner
    import gn2d_pkg::*;
(
    input  logic                    aclk,
    input  logic                    en,
    input  logic [31:0]             seed,
    input  logic [GRID_W-1:0]       gx,
    input  logic [GRID_W-1:0]       gy,
    input  logic signed [OFS_W-1:0] ox,
    input  logic signed [OFS_W-1:0] oy,
    output logic signed [DOT_W-1:0] dot
);

    // hash
    logic [31:0] p1_reg, p2_reg;
    logic [31:0] h0, h1, h2, mag;
    // mod 62832
    logic        sgn3_reg, sgn4_reg, sgn5_reg, sgn6_reg, sgn7_reg;
    logic [27:0] m4_reg;
    logic [3:0]  lo3_reg, lo4_reg;
    logic [16:0] qa_reg;
    logic [44:0] qprod;
    logic [29:0] r1w;
    logic [12:0] rem_reg;
    logic [12:0] r4;
    logic [27:0] n4_reg, n6_reg;
    logic [46:0] dprod;
    logic [18:0] qa2_reg, qa7_reg;
    logic [29:0] r2w;
    logic [10:0] rem2_reg;
    // angle
    logic [CS_W-1:0]        am;
    logic signed [CS_W-1:0] as_v, aw;
    logic signed [CS_W-1:0] a8_reg;
    // cordic
    logic signed [CS_W-1:0] cx_reg [0:CORDIC_STEPS];
    logic signed [CS_W-1:0] cy_reg [0:CORDIC_STEPS];
    logic signed [CS_W-1:0] z_reg  [0:CORDIC_STEPS-1];
    logic                   flip_reg [9:25];
    logic signed [OFS_W-1:0] ox_reg [1:26];
    logic signed [OFS_W-1:0] oy_reg [1:26];
    // dot
    logic signed [CS_W-1:0]       c_reg, s_reg;
    logic signed [CS_W+OFS_W-1:0] pc_reg, ps_reg;
    logic signed [DOT_W-1:0]      dot_reg;

    always_comb begin
        h0  = {{(32-GRID_W){1'b0}}, gy} ^ {{(32-GRID_W){1'b0}}, gx} ^ seed;
        h1  = p1_reg ^ 32'($signed(p1_reg) >>> 4);
        h2  = p2_reg ^ 32'($signed(p2_reg) >>> 11);
        mag = h2[31] ? (~h2 + 32'd1) : h2;
        qprod = 45'(mag[31:4]) * 45'(MOD_K);
        r1w = 30'(m4_reg) - 30'(qa_reg) * 30'(MOD_D);
        r4  = (rem_reg >= 13'(MOD_D)) ? (rem_reg - 13'(MOD_D)) : rem_reg;
        dprod = 47'(n4_reg) * 47'(DEG_K);
        r2w = 30'(n6_reg) - 30'(qa2_reg) * 30'(DEG_D);
        am  = CS_W'(qa7_reg) + CS_W'(rem2_reg >= 11'(DEG_D));
        as_v = sgn7_reg ? -$signed(am) : $signed(am);
        if (as_v > Q16_PI) begin
            aw = as_v - Q16_TWO_PI;
        end else if (as_v < -Q16_PI) begin
            aw = as_v + Q16_TWO_PI;
        end else begin
            aw = as_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // k1, k2: two multiply rounds
            p1_reg <= h0 * HASH_M1;
            p2_reg <= h1 * HASH_M2;
            // k3: magnitude and quotient estimate
            sgn3_reg <= h2[31];
            m4_reg   <= mag[31:4];
            lo3_reg  <= mag[3:0];
            qa_reg   <= qprod[44:28];
            // k4: remainder, at most one divisor too large
            sgn4_reg <= sgn3_reg;
            lo4_reg  <= lo3_reg;
            rem_reg  <= r1w[12:0];
            // k5: fixed remainder, rescale toward Q16
            sgn5_reg <= sgn4_reg;
            n4_reg   <= {r4[11:0], lo4_reg, 12'd0} + DEG_BIAS;
            // k6, k7: divide by 625
            sgn6_reg <= sgn5_reg;
            n6_reg   <= n4_reg;
            qa2_reg  <= dprod[46:28];
            sgn7_reg <= sgn6_reg;
            qa7_reg  <= qa2_reg;
            rem2_reg <= r2w[10:0];
            // k8: signed angle wrapped to [-pi, pi]
            a8_reg <= aw;
            // k9: fold into [-pi/2, pi/2]
            cx_reg[0] <= CORDIC_GAIN;
            cy_reg[0] <= '0;
            if (a8_reg > Q16_HALF_PI) begin
                z_reg[0]    <= a8_reg - Q16_PI;
                flip_reg[9] <= 1'b1;
            end else if (a8_reg < -Q16_HALF_PI) begin
                z_reg[0]    <= a8_reg + Q16_PI;
                flip_reg[9] <= 1'b1;
            end else begin
                z_reg[0]    <= a8_reg;
                flip_reg[9] <= 1'b0;
            end
            ox_reg[1] <= ox;
            oy_reg[1] <= oy;
            // k26..k28: undo fold, dot product
            c_reg   <= flip_reg[25] ? -cx_reg[CORDIC_STEPS] : cx_reg[CORDIC_STEPS];
            s_reg   <= flip_reg[25] ? -cy_reg[CORDIC_STEPS] : cy_reg[CORDIC_STEPS];
            pc_reg  <= c_reg * ox_reg[26];
            ps_reg  <= s_reg * oy_reg[26];
            dot_reg <= DOT_W'(pc_reg) + DOT_W'(ps_reg);
        end
    end

    genvar k, i;
    generate
        for (k = 2; k <= 26; k++) begin : g_ofs
            always_ff @(posedge aclk) begin
                if (en) begin
                    ox_reg[k] <= ox_reg[k-1];
                    oy_reg[k] <= oy_reg[k-1];
                end
            end
        end
        for (k = 10; k <= 25; k++) begin : g_flip
            always_ff @(posedge aclk) begin
                if (en) begin
                    flip_reg[k] <= flip_reg[k-1];
                end
            end
        end
        // k10..k25: one rotation per stage
        for (i = 0; i < CORDIC_STEPS; i++) begin : g_rot
            always_ff @(posedge aclk) begin
                if (en) begin
                    if (z_reg[i] >= 0) begin
                        cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                        cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                    end else begin
                        cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                        cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                    end
                end
            end
            if (i < CORDIC_STEPS - 1) begin : g_z
                always_ff @(posedge aclk) begin
                    if (en) begin
                        z_reg[i+1] <= (z_reg[i] >= 0) ? (z_reg[i] - atan_q16(i))
                                                      : (z_reg[i] + atan_q16(i));
                    end
                end
            end
        end
    endgenerate

    assign dot = dot_reg;

endmodule

// ===== sv/gradient_noise_2d.sv =====
// Pipeline: an input register, 28 corner stages, 6 blend stages and 4 output stages lie
// between the edge that accepts a request and the edge that presents its result.
// One request per cycle when not halted; eight corner pipelines work side by side.
// The whole pipeline advances together; it halts only while the output holds a result
// that is not taken. Reset (aresetn low, synchronous) empties all stages, seed = 0.
// Depends on gn2d_pkg and gn2d_corner.
module gradient_noise_2d
    import gn2d_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // requests
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [COORD_W-1:0]  s_x_coord,
    input  logic [COORD_W-1:0]  s_y_coord,
    input  logic                s_mode,
    // results
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [15:0]  m_noise_value
);

    localparam int LAST_STAGE = 37;

    typedef struct packed {
        logic [WGT_W-1:0] wx1;
        logic [WGT_W-1:0] wy1;
        logic [WGT_W-1:0] wx4;
        logic [WGT_W-1:0] wy4;
    } weight_t;

    // Global advance: every stage moves when the output slot is free or being taken.
    logic adv;
    logic vld_reg [0:LAST_STAGE];
    logic m_valid_reg;
    logic signed [15:0] m_noise_value_reg;
    logic [31:0] seed_reg;

    // Stage 0: captured request
    logic [COORD_W-1:0] x0_reg, y0_reg;
    logic               mode_reg [0:34];

    // Lattice split of both octaves
    logic [GRID_W-1:0] gx1, gy1, gx4, gy4;
    logic [15:0]       fx1, fy1, fx4, fy4;
    logic [15:0]       fu [4];

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_NOISE_SEED) ? seed_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else if (psel && penable && pwrite && paddr[2] == REG_NOISE_SEED) begin
            seed_reg <= pwdata;
        end
    end

    // Octave 1 cell and fraction; octave 4 is the same point shifted left two bits.
    always_comb begin
        gx1 = GRID_W'(x0_reg[COORD_W-1:FRAC_BITS]);
        gy1 = GRID_W'(y0_reg[COORD_W-1:FRAC_BITS]);
        gx4 = GRID_W'(x0_reg[COORD_W-1:FRAC_BITS-2]);
        gy4 = GRID_W'(y0_reg[COORD_W-1:FRAC_BITS-2]);
        fx1 = {x0_reg[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
        fy1 = {y0_reg[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
        fx4 = {x0_reg[FRAC_BITS-3:0], {(18-FRAC_BITS){1'b0}}};
        fy4 = {y0_reg[FRAC_BITS-3:0], {(18-FRAC_BITS){1'b0}}};
        fu[0] = fx1;
        fu[1] = fy1;
        fu[2] = fx4;
        fu[3] = fy4;
    end

    // Eight corners: index = octave*4 + dy*2 + dx.
    logic signed [DOT_W-1:0] dot [8];

    genvar j;
    generate
        for (j = 0; j < 8; j++) begin : g_corner
            logic [GRID_W-1:0]       cgx, cgy;
            logic [15:0]             cfx, cfy;
            logic signed [OFS_W-1:0] cox, coy;
            always_comb begin
                cgx = (j < 4) ? gx1 : gx4;
                cgy = (j < 4) ? gy1 : gy4;
                cfx = (j < 4) ? fx1 : fx4;
                cfy = (j < 4) ? fy1 : fy4;
                if (j % 2 == 1) begin
                    cgx = cgx + GRID_W'(1);
                    cox = $signed({1'b0, cfx}) - $signed(OFS_W'(65536));
                end else begin
                    cox = $signed({1'b0, cfx});
                end
                if ((j / 2) % 2 == 1) begin
                    cgy = cgy + GRID_W'(1);
                    coy = $signed({1'b0, cfy}) - $signed(OFS_W'(65536));
                end else begin
                    coy = $signed({1'b0, cfy});
                end
            end
            gn2d_corner u_corner (
                .aclk (aclk),
                .en   (adv),
                .seed (seed_reg),
                .gx   (cgx),
                .gy   (cgy),
                .ox   (cox),
                .oy   (coy),
                .dot  (dot[j])
            );
        end
    endgenerate

    // Fade 6t^5 - 15t^4 + 10t^3 in Q16, Horner form, stages 1..5, four lanes.
    logic signed [20:0] fa_reg [4];
    logic [19:0]        fb_reg [4], fc_reg [4], fd_reg [4];
    logic [15:0]        fu1_reg [4], fu2_reg [4], fu3_reg [4], fu4_reg [4];
    logic signed [37:0] fbp [4];
    logic signed [21:0] fbs [4];
    logic [35:0]        fcp [4], fdp [4];
    logic [35:0]        ffp [4];
    weight_t            wgt_reg [5:32];

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            fbp[l] = $signed({1'b0, fu1_reg[l]}) * fa_reg[l];
            fbs[l] = fbp[l][37:16] + 22'sd655360;
            fcp[l] = fu2_reg[l] * fb_reg[l];
            fdp[l] = fu3_reg[l] * fc_reg[l];
            ffp[l] = fu4_reg[l] * fd_reg[l];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < 4; l++) begin
                fa_reg[l]  <= $signed({5'd0, fu[l]}) * 21'sd6 - 21'sd983040;
                fu1_reg[l] <= fu[l];
                fb_reg[l]  <= fbs[l][19:0];
                fu2_reg[l] <= fu1_reg[l];
                fc_reg[l]  <= fcp[l][35:16];
                fu3_reg[l] <= fu2_reg[l];
                fd_reg[l]  <= fdp[l][35:16];
                fu4_reg[l] <= fu3_reg[l];
            end
            wgt_reg[5].wx1 <= ffp[0][32:16];
            wgt_reg[5].wy1 <= ffp[1][32:16];
            wgt_reg[5].wx4 <= ffp[2][32:16];
            wgt_reg[5].wy4 <= ffp[3][32:16];
        end
    end

    genvar k;
    generate
        for (k = 6; k <= 32; k++) begin : g_wgt
            always_ff @(posedge aclk) begin
                if (adv) begin
                    wgt_reg[k] <= wgt_reg[k-1];
                end
            end
        end
        for (k = 1; k <= 34; k++) begin : g_mode
            always_ff @(posedge aclk) begin
                if (adv) begin
                    mode_reg[k] <= mode_reg[k-1];
                end
            end
        end
        for (k = 1; k <= LAST_STAGE; k++) begin : g_vld
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (adv) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    endgenerate

    // Blend stages 29..34, one lane per octave: x lerp on both rows, then y lerp.
    logic signed [DOT_W-1:0] ba_reg [2], bc_reg [2];
    logic signed [DOT_W:0]   bdx_reg [2], bdz_reg [2];
    logic signed [DOT_W-1:0] ba2_reg [2], bc2_reg [2];
    logic signed [56:0]      pmx_reg [2], pmz_reg [2];
    logic signed [DOT_W-1:0] i0_reg [2], i1_reg [2];
    logic signed [DOT_W-1:0] i0b_reg [2], i0c_reg [2];
    logic signed [DOT_W:0]   dy_reg [2];
    logic signed [56:0]      pmy_reg [2];
    logic signed [DOT_W-1:0] nb_reg [2];
    logic [WGT_W-1:0]        wx [2], wy [2];

    always_comb begin
        wx[0] = wgt_reg[29].wx1;
        wx[1] = wgt_reg[29].wx4;
        wy[0] = wgt_reg[32].wy1;
        wy[1] = wgt_reg[32].wy4;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int o = 0; o < 2; o++) begin
                ba_reg[o]  <= dot[4*o];
                bc_reg[o]  <= dot[4*o+2];
                bdx_reg[o] <= (DOT_W+1)'(dot[4*o+1]) - (DOT_W+1)'(dot[4*o]);
                bdz_reg[o] <= (DOT_W+1)'(dot[4*o+3]) - (DOT_W+1)'(dot[4*o+2]);
                ba2_reg[o] <= ba_reg[o];
                bc2_reg[o] <= bc_reg[o];
                pmx_reg[o] <= $signed({1'b0, wx[o]}) * bdx_reg[o];
                pmz_reg[o] <= $signed({1'b0, wx[o]}) * bdz_reg[o];
                i0_reg[o]  <= ba2_reg[o] + DOT_W'(pmx_reg[o] >>> 16);
                i1_reg[o]  <= bc2_reg[o] + DOT_W'(pmz_reg[o] >>> 16);
                i0b_reg[o] <= i0_reg[o];
                dy_reg[o]  <= (DOT_W+1)'(i1_reg[o]) - (DOT_W+1)'(i0_reg[o]);
                i0c_reg[o] <= i0b_reg[o];
                pmy_reg[o] <= $signed({1'b0, wy[o]}) * dy_reg[o];
                nb_reg[o]  <= i0c_reg[o] + DOT_W'(pmy_reg[o] >>> 16);
            end
        end
    end

    // Output stages 35..38: octave mix, round half away from zero to Q2.13, saturate.
    // With n = 2*blend: q = round(|num| / 3*2^20) = floor((|v| + 3*2^18) / 2^19 / 3).
    logic signed [39:0] v_reg;
    logic               neg2_reg, neg3_reg;
    logic [39:0]        vmag;
    logic [40:0]        vrnd;
    logic [21:0]        n2_reg, n3_reg;
    logic [42:0]        q3p;
    logic [20:0]        q3_reg;
    logic [23:0]        r3;
    logic [20:0]        qf;
    logic signed [15:0] res;

    always_comb begin
        vmag = v_reg[39] ? 40'(-v_reg) : 40'(v_reg);
        vrnd = 41'(vmag) + 41'd786432;
        q3p  = 43'(n2_reg) * 43'd1398101;
        r3   = 24'(n3_reg) - 24'(q3_reg) * 24'd3;
        qf   = q3_reg + 21'(r3 >= 24'd3);
        if (!neg3_reg) begin
            res = (qf > 21'd32767) ? 16'sh7fff : $signed(qf[15:0]);
        end else begin
            res = (qf > 21'd32768) ? 16'sh8000 : -$signed(qf[15:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x0_reg      <= s_x_coord;
            y0_reg      <= s_y_coord;
            mode_reg[0] <= s_mode;
            v_reg <= mode_reg[34] ? (40'(nb_reg[1]) + 40'(nb_reg[0]) * 40'sd2)
                                  : (40'(nb_reg[0]) * 40'sd3);
            neg2_reg <= v_reg[39];
            n2_reg   <= vrnd[40:19];
            neg3_reg <= neg2_reg;
            n3_reg   <= n2_reg;
            q3_reg   <= q3p[42:22];
            m_noise_value_reg <= res;
        end
    end

    // Request valid enters stage 0; result valid leaves the last stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0]  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg[0]  <= s_valid;
            m_valid_reg <= vld_reg[LAST_STAGE];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_noise_value = m_noise_value_reg;

endmodule
